FILE: design/ris_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ris_pkg: shared types and codes for the record insertion sorter
// Transfer payloads, command codes and the record store access request.
// ----------------------------------------------------------------------------
package ris_pkg;

  localparam int WORD_W = 64;

  // command codes
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_SORT = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // result status codes
  localparam logic ST_DONE  = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [5:0]        record_index;
    logic [2:0]        word_index;
    logic [WORD_W-1:0] word_data;
    logic [6:0]        sort_count;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_word;
    logic              status;
  } out_item_t;

  // one access to the record store: word indices are within a record
  typedef struct packed {
    logic       key_we;
    logic       pay_we;
    logic [2:0] rd_kw;
    logic [2:0] rd_pw;
    logic [2:0] wr_kw;
    logic [2:0] wr_pw;
  } mem_req_t;

endpackage
`default_nettype wire

FILE: design/ris_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ris_store: key and payload memories
// Two word memories, one write and one registered read port each.
// ----------------------------------------------------------------------------
module ris_store #(
  parameter int MAX_RECORDS   = 64,
  parameter int KEY_WORDS     = 4,
  parameter int PAYLOAD_WORDS = 2,
  localparam int RW = $clog2(MAX_RECORDS)
) (
  input  wire logic                      clk,
  input  wire ris_pkg::mem_req_t         req,
  input  wire logic [RW-1:0]             rd_rec,
  input  wire logic [RW-1:0]             wr_rec,
  input  wire logic [ris_pkg::WORD_W-1:0] wr_kdata,
  input  wire logic [ris_pkg::WORD_W-1:0] wr_pdata,
  output logic      [ris_pkg::WORD_W-1:0] kq,
  output logic      [ris_pkg::WORD_W-1:0] pq
);

  localparam int KDEPTH = MAX_RECORDS * KEY_WORDS;
  localparam int PDEPTH = MAX_RECORDS * PAYLOAD_WORDS;
  localparam int KA = $clog2(KDEPTH);
  localparam int PA = $clog2(PDEPTH);

  logic [ris_pkg::WORD_W-1:0] key_mem_r [KDEPTH];
  logic [ris_pkg::WORD_W-1:0] pay_mem_r [PDEPTH];
  logic [ris_pkg::WORD_W-1:0] kq_r;
  logic [ris_pkg::WORD_W-1:0] pq_r;
  logic [KA-1:0] k_raddr;
  logic [KA-1:0] k_waddr;
  logic [PA-1:0] p_raddr;
  logic [PA-1:0] p_waddr;

  // record-major layout: record * words_per_record + word
  assign k_raddr = KA'(rd_rec) * KA'(KEY_WORDS) + KA'(req.rd_kw);
  assign k_waddr = KA'(wr_rec) * KA'(KEY_WORDS) + KA'(req.wr_kw);
  assign p_raddr = PA'(rd_rec) * PA'(PAYLOAD_WORDS) + PA'(req.rd_pw);
  assign p_waddr = PA'(wr_rec) * PA'(PAYLOAD_WORDS) + PA'(req.wr_pw);

  always_ff @(posedge clk) begin
    if (req.key_we) begin
      key_mem_r[k_waddr] <= wr_kdata;
    end
    kq_r <= key_mem_r[k_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.pay_we) begin
      pay_mem_r[p_waddr] <= wr_pdata;
    end
    pq_r <= pay_mem_r[p_raddr];
  end

  assign kq = kq_r;
  assign pq = pq_r;

endmodule
`default_nettype wire

FILE: design/ris_sorter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ris_sorter: insertion sort sequencer
// Holds the record being inserted, walks it down word by word through the
// store, shifting larger records up one slot.
// ----------------------------------------------------------------------------
module ris_sorter #(
  parameter int MAX_RECORDS   = 64,
  parameter int KEY_WORDS     = 4,
  parameter int PAYLOAD_WORDS = 2,
  localparam int RW = $clog2(MAX_RECORDS)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [6:0]                 count,
  output logic                            done,
  output ris_pkg::mem_req_t               req,
  output logic      [RW-1:0]              rd_rec,
  output logic      [RW-1:0]              wr_rec,
  output logic      [ris_pkg::WORD_W-1:0] wr_kdata,
  output logic      [ris_pkg::WORD_W-1:0] wr_pdata,
  input  wire logic [ris_pkg::WORD_W-1:0] kq,
  input  wire logic [ris_pkg::WORD_W-1:0] pq
);

  localparam int NW  = (KEY_WORDS > PAYLOAD_WORDS) ? KEY_WORDS : PAYLOAD_WORDS;
  localparam int CW  = $clog2(MAX_RECORDS + 1);
  localparam int KIW = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int PIW = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_TLOAD = 5'b00010,
    S_CMP   = 5'b00100,
    S_MOVE  = 5'b01000,
    S_PUT   = 5'b10000
  } sort_st_t;

  sort_st_t st_r, st_nxt;
  logic [RW-1:0] i_r, i_nxt;
  logic [RW-1:0] j_r, j_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [2:0]    wc_r, wc_nxt;    // issue word counter
  logic          iss_r, iss_nxt;  // reads still to issue
  logic [2:0]    wd_r, wd_nxt;    // word index of data arriving now
  logic          dv_r, dv_nxt;    // read data valid this cycle

  logic [ris_pkg::WORD_W-1:0] tk_r [KEY_WORDS];
  logic [ris_pkg::WORD_W-1:0] tp_r [PAYLOAD_WORDS];

  logic [2:0]    kwc, pwc;
  logic          wc_is_key, wc_is_pay, wd_is_key, wd_is_pay;
  logic [RW-1:0] jm1;
  logic [ris_pkg::WORD_W-1:0] tkw;
  logic          last_nw, last_k, wd_last_nw, wd_last_k;

  assign wc_is_key  = {1'b0, wc_r} < 4'(KEY_WORDS);
  assign wc_is_pay  = {1'b0, wc_r} < 4'(PAYLOAD_WORDS);
  assign wd_is_key  = {1'b0, wd_r} < 4'(KEY_WORDS);
  assign wd_is_pay  = {1'b0, wd_r} < 4'(PAYLOAD_WORDS);
  assign kwc        = wc_is_key ? wc_r : 3'(KEY_WORDS - 1);
  assign pwc        = wc_is_pay ? wc_r : 3'(PAYLOAD_WORDS - 1);
  assign jm1        = j_r - RW'(1);
  assign tkw        = tk_r[wd_r[KIW-1:0]];
  assign last_nw    = wc_r == 3'(NW - 1);
  assign last_k     = wc_r == 3'(KEY_WORDS - 1);
  assign wd_last_nw = wd_r == 3'(NW - 1);
  assign wd_last_k  = wd_r == 3'(KEY_WORDS - 1);

  always_comb begin
    st_nxt   = st_r;
    i_nxt    = i_r;
    j_nxt    = j_r;
    cnt_nxt  = cnt_r;
    wc_nxt   = wc_r;
    iss_nxt  = iss_r;
    wd_nxt   = wd_r;
    dv_nxt   = 1'b0;
    done     = 1'b0;
    req      = '0;
    req.rd_kw = kwc;
    req.rd_pw = pwc;
    rd_rec   = (st_r == S_TLOAD) ? i_r : jm1;
    wr_rec   = j_r;
    wr_kdata = kq;
    wr_pdata = pq;

    // streaming reads for the read-driven states
    if ((st_r == S_TLOAD || st_r == S_CMP || st_r == S_MOVE) && iss_r) begin
      dv_nxt = 1'b1;
      wd_nxt = wc_r;
      wc_nxt = wc_r + 3'd1;
      if ((st_r == S_CMP) ? last_k : last_nw) begin
        iss_nxt = 1'b0;
      end
    end

    case (st_r)
      S_IDLE: begin
        if (start) begin
          i_nxt   = RW'(1);
          cnt_nxt = CW'(count);
          st_nxt  = S_TLOAD;
          wc_nxt  = 3'd0;
          iss_nxt = 1'b1;
        end
      end
      S_TLOAD: begin
        if (dv_r && wd_last_nw) begin
          j_nxt   = i_r;
          st_nxt  = S_CMP;
          wc_nxt  = 3'd0;
          iss_nxt = 1'b1;
          dv_nxt  = 1'b0;
        end
      end
      S_CMP: begin
        // stored key strictly greater: shift it up; otherwise slot found
        if (dv_r && (kq != tkw || wd_last_k)) begin
          st_nxt  = (kq > tkw) ? S_MOVE : S_PUT;
          wc_nxt  = 3'd0;
          iss_nxt = 1'b1;
          dv_nxt  = 1'b0;
        end
      end
      S_MOVE: begin
        req.key_we = dv_r && wd_is_key;
        req.pay_we = dv_r && wd_is_pay;
        req.wr_kw  = wd_r;
        req.wr_pw  = wd_r;
        if (dv_r && wd_last_nw) begin
          j_nxt   = jm1;
          st_nxt  = (jm1 == '0) ? S_PUT : S_CMP;
          wc_nxt  = 3'd0;
          iss_nxt = 1'b1;
          dv_nxt  = 1'b0;
        end
      end
      S_PUT: begin
        req.key_we = wc_is_key;
        req.pay_we = wc_is_pay;
        req.wr_kw  = wc_r;
        req.wr_pw  = wc_r;
        wr_kdata   = tk_r[kwc[KIW-1:0]];
        wr_pdata   = tp_r[pwc[PIW-1:0]];
        wc_nxt     = wc_r + 3'd1;
        if (last_nw) begin
          wc_nxt  = 3'd0;
          iss_nxt = 1'b1;
          if (CW'(i_r) + CW'(1) == cnt_r) begin
            done   = 1'b1;
            st_nxt = S_IDLE;
          end else begin
            i_nxt  = i_r + RW'(1);
            st_nxt = S_TLOAD;
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      iss_r <= 1'b0;
      dv_r  <= 1'b0;
      wc_r  <= 3'd0;
    end else begin
      st_r  <= st_nxt;
      iss_r <= iss_nxt;
      dv_r  <= dv_nxt;
      wc_r  <= wc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    cnt_r <= cnt_nxt;
    wd_r  <= wd_nxt;
  end

  // record being inserted
  always_ff @(posedge clk) begin
    if (st_r == S_TLOAD && dv_r) begin
      if (wd_is_key) begin
        tk_r[wd_r[KIW-1:0]] <= kq;
      end
      if (wd_is_pay) begin
        tp_r[wd_r[PIW-1:0]] <= pq;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/record_insertion_sorter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// record_insertion_sorter_top: stable insertion sort over stored records
// Command front end, store port arbitration and the result register.
// ----------------------------------------------------------------------------
// The block keeps MAX_RECORDS records, each KEY_WORDS key words and
// PAYLOAD_WORDS payload words, in two single-port-write word memories with
// registered reads. Keys order as unsigned words, word 0 first, which is
// byte-lexicographic order for zero-padded strings. One command is taken
// per input transfer and gives exactly one result transfer. A load, a bad
// command, a bad index or count, and a sort of zero or one records are
// answered as soon as they are taken. A read first waits out the
// registered memory read. A sort holds in_stall high for its whole run,
// which is set by the single read port of the store: each inserted record
// is fetched word by word, its key is compared word by word against each
// record below it, every larger record is read and written one slot up,
// and the inserted record is then written into its slot, so the run of a
// reverse-ordered input grows with the square of the record count. A
// finished result sits in an output register; the next command is taken
// while that result is being transferred. No clearing pass runs after
// reset; the store contents are undefined until loaded.
// ----------------------------------------------------------------------------
module record_insertion_sorter_top #(
  parameter int MAX_RECORDS   = 64,
  parameter int KEY_WORDS     = 4,
  parameter int PAYLOAD_WORDS = 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ris_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ris_pkg::out_item_t      out_data
);

  localparam int RW = $clog2(MAX_RECORDS);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_READ = 3'b010,
    T_SORT = 3'b100
  } top_st_t;

  top_st_t st_r, st_nxt;
  logic    key_sel_r, key_sel_nxt;   // pending read comes from the key memory
  logic    out_valid_r, out_valid_nxt;
  ris_pkg::out_item_t out_data_r, out_data_nxt;

  logic in_acc, out_free;
  logic rec_ok, wrd_ok, cnt_ok, is_key;
  logic [3:0] pw_full;
  logic sort_start, sort_done;

  // store port signals: host path, sorter path, selected
  ris_pkg::mem_req_t host_req, srt_req, mem_req;
  logic [RW-1:0] host_rec, srt_rd_rec, srt_wr_rec, mem_rd_rec, mem_wr_rec;
  logic [ris_pkg::WORD_W-1:0] srt_kdata, srt_pdata, mem_kdata, mem_pdata;
  logic [ris_pkg::WORD_W-1:0] kq, pq;

  // result
  logic res_now, res_status;
  logic [ris_pkg::WORD_W-1:0] res_word;

  // ---------------------------------------------------------------------------
  // handshake: one command in flight, result register must be free or
  // draining this cycle
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((st_r == T_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // range checks and word addressing
  // ---------------------------------------------------------------------------
  assign rec_ok  = 32'(in_data.record_index) < 32'(MAX_RECORDS);
  assign wrd_ok  = 32'(in_data.word_index) < 32'(KEY_WORDS + PAYLOAD_WORDS);
  assign cnt_ok  = 32'(in_data.sort_count) <= 32'(MAX_RECORDS);
  assign is_key  = {1'b0, in_data.word_index} < 4'(KEY_WORDS);
  assign pw_full = {1'b0, in_data.word_index} - 4'(KEY_WORDS);
  assign host_rec = RW'(in_data.record_index);

  always_comb begin
    host_req        = '0;
    host_req.rd_kw  = in_data.word_index;
    host_req.wr_kw  = in_data.word_index;
    host_req.rd_pw  = pw_full[2:0];
    host_req.wr_pw  = pw_full[2:0];
    host_req.key_we = in_acc && (in_data.cmd == ris_pkg::CMD_LOAD) &&
                      rec_ok && wrd_ok && is_key;
    host_req.pay_we = in_acc && (in_data.cmd == ris_pkg::CMD_LOAD) &&
                      rec_ok && wrd_ok && !is_key;
  end

  // a sort of zero or one records is answered at once
  assign sort_start = in_acc && (in_data.cmd == ris_pkg::CMD_SORT) && cnt_ok &&
                      (in_data.sort_count > 7'd1);

  // sorter owns the store for the whole run
  always_comb begin
    if (st_r == T_SORT) begin
      mem_req    = srt_req;
      mem_rd_rec = srt_rd_rec;
      mem_wr_rec = srt_wr_rec;
      mem_kdata  = srt_kdata;
      mem_pdata  = srt_pdata;
    end else begin
      mem_req    = host_req;
      mem_rd_rec = host_rec;
      mem_wr_rec = host_rec;
      mem_kdata  = in_data.word_data;
      mem_pdata  = in_data.word_data;
    end
  end

  // ---------------------------------------------------------------------------
  // command sequencing
  // ---------------------------------------------------------------------------
  always_comb begin
    st_nxt      = st_r;
    key_sel_nxt = key_sel_r;
    res_now     = 1'b0;
    res_status  = ris_pkg::ST_DONE;
    res_word    = '0;

    case (st_r)
      T_IDLE: begin
        if (in_acc) begin
          case (in_data.cmd)
            ris_pkg::CMD_LOAD: begin
              res_now    = 1'b1;
              res_status = (rec_ok && wrd_ok) ? ris_pkg::ST_DONE : ris_pkg::ST_RANGE;
            end
            ris_pkg::CMD_READ: begin
              if (rec_ok && wrd_ok) begin
                st_nxt      = T_READ;
                key_sel_nxt = is_key;
              end else begin
                res_now    = 1'b1;
                res_status = ris_pkg::ST_RANGE;
              end
            end
            ris_pkg::CMD_SORT: begin
              if (sort_start) begin
                st_nxt = T_SORT;
              end else begin
                res_now    = 1'b1;
                res_status = cnt_ok ? ris_pkg::ST_DONE : ris_pkg::ST_RANGE;
              end
            end
            default: begin
              res_now    = 1'b1;
              res_status = ris_pkg::ST_RANGE;
            end
          endcase
        end
      end
      T_READ: begin
        res_now  = 1'b1;
        res_word = key_sel_r ? kq : pq;
        st_nxt   = T_IDLE;
      end
      T_SORT: begin
        if (sort_done) begin
          res_now = 1'b1;
          st_nxt  = T_IDLE;
        end
      end
      default: begin
        st_nxt = T_IDLE;
      end
    endcase
  end

  // result register: commands are only taken while it is free, so a new
  // result never lands on a stalled one
  always_comb begin
    out_valid_nxt = res_now || (out_valid_r && out_stall);
    out_data_nxt  = out_data_r;
    if (res_now) begin
      out_data_nxt.read_word = res_word;
      out_data_nxt.status    = res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_sel_r  <= key_sel_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // sort engine and record store
  // ---------------------------------------------------------------------------
  ris_sorter #(
    .MAX_RECORDS  (MAX_RECORDS),
    .KEY_WORDS    (KEY_WORDS),
    .PAYLOAD_WORDS(PAYLOAD_WORDS)
  ) u_sorter (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sort_start),
    .count   (in_data.sort_count),
    .done    (sort_done),
    .req     (srt_req),
    .rd_rec  (srt_rd_rec),
    .wr_rec  (srt_wr_rec),
    .wr_kdata(srt_kdata),
    .wr_pdata(srt_pdata),
    .kq      (kq),
    .pq      (pq)
  );

  ris_store #(
    .MAX_RECORDS  (MAX_RECORDS),
    .KEY_WORDS    (KEY_WORDS),
    .PAYLOAD_WORDS(PAYLOAD_WORDS)
  ) u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_rec  (mem_rd_rec),
    .wr_rec  (mem_wr_rec),
    .wr_kdata(mem_kdata),
    .wr_pdata(mem_pdata),
    .kq      (kq),
    .pq      (pq)
  );

endmodule
`default_nettype wire

FILE: design/ris_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ris_checker: port-level checks for the record insertion sorter
// Watches the command and result transfers and their timing.
// ----------------------------------------------------------------------------
module ris_checker #(
  parameter int MAX_RECORDS   = 64,
  parameter int KEY_WORDS     = 4,
  parameter int PAYLOAD_WORDS = 2
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire ris_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire ris_pkg::out_item_t out_data
);

  logic acc, good_read, long_sort;

  assign acc       = in_valid && !in_stall;
  assign good_read = acc && (in_data.cmd == ris_pkg::CMD_READ) &&
                     (32'(in_data.record_index) < 32'(MAX_RECORDS)) &&
                     (32'(in_data.word_index) < 32'(KEY_WORDS + PAYLOAD_WORDS));
  assign long_sort = acc && (in_data.cmd == ris_pkg::CMD_SORT) &&
                     (32'(in_data.sort_count) <= 32'(MAX_RECORDS)) &&
                     (in_data.sort_count > 7'd1);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // no command taken while a result is stuck
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("command taken while result stalled");

  // loads and unused commands answer next cycle with a zero word
  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_data.cmd != ris_pkg::CMD_READ) && (in_data.cmd != ris_pkg::CMD_SORT)
    |=> out_valid && (out_data.read_word == '0))
    else $error("load or unused command result wrong");

  // good read returns after the memory latency with status done
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    good_read |=> !out_valid ##1 (out_valid && (out_data.status == ris_pkg::ST_DONE)))
    else $error("read result timing wrong");

  // a real sort keeps the input stalled with no result the next cycle
  a_sort_busy: assert property (@(posedge clk) disable iff (!rst_n)
    long_sort |=> in_stall && !out_valid)
    else $error("sort did not hold off input");

endmodule

bind record_insertion_sorter_top ris_checker #(
  .MAX_RECORDS  (MAX_RECORDS),
  .KEY_WORDS    (KEY_WORDS),
  .PAYLOAD_WORDS(PAYLOAD_WORDS)
) u_ris_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: record insertion sorter
// Drives load, sort and read commands through the valid/stall input channel.
// A behavioral copy of the record store predicts every reply, and each reply
// transfer is checked field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // block geometry at its default parameters
  localparam int N_RECORDS = 64;
  localparam int N_KEY     = 4;
  localparam int N_PAY     = 2;
  localparam int N_WORDS   = N_KEY + N_PAY;

  // command code the block does not define
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // A reversed 64-record sort runs long; the limit allows many of them on
  // top of ~950 transfers under heavy stalling.
  localparam int LIMIT_CYCLES  = 3_000_000;
  // cycles to watch for stray replies once nothing is pending
  localparam int SETTLE_CYCLES = 20;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  ris_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ris_pkg::out_item_t out_data;

  record_insertion_sorter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Idle rates in percent per cycle, changed between phases.
  int send_idle_pct = 23;
  int recv_idle_pct = 61;

  int error_count = 0;
  int cycle_count = 0;
  int sent_items  = 0;

  // Predicted replies, oldest first.
  ris_pkg::out_item_t pending_replies[$];

  // Shadow copy of the record store.
  logic [63:0] key_mem [N_RECORDS][N_KEY];
  logic [63:0] pay_mem [N_RECORDS][N_PAY];

  // --------------------------------------------------------------------------
  // Predictor: applies one accepted command to the shadow store and returns
  // the reply it must produce.
  // --------------------------------------------------------------------------
  function automatic ris_pkg::out_item_t apply_command(ris_pkg::in_item_t it);
    ris_pkg::out_item_t r;
    int          count;
    int          j;
    bit          gt;
    bit          decided;
    bit          shifting;
    logic [63:0] t;
    r.read_word = '0;
    r.status    = ris_pkg::ST_DONE;
    case (it.cmd)
      ris_pkg::CMD_LOAD, ris_pkg::CMD_READ: begin
        // record_index is 6 bits wide, so only the word index can be bad
        if (it.word_index >= N_WORDS) begin
          r.status = ris_pkg::ST_RANGE;
        end else if (it.cmd == ris_pkg::CMD_LOAD) begin
          if (it.word_index < N_KEY)
            key_mem[it.record_index][it.word_index] = it.word_data;
          else
            pay_mem[it.record_index][it.word_index - N_KEY] = it.word_data;
        end else begin
          if (it.word_index < N_KEY)
            r.read_word = key_mem[it.record_index][it.word_index];
          else
            r.read_word = pay_mem[it.record_index][it.word_index - N_KEY];
        end
      end
      ris_pkg::CMD_SORT: begin
        count = int'(it.sort_count);
        if (count > N_RECORDS) begin
          r.status = ris_pkg::ST_RANGE;
        end else begin
          // stable insertion sort: only a strictly greater key moves up
          for (int i = 1; i < count; i++) begin
            j = i;
            shifting = 1'b1;
            while (shifting && j > 0) begin
              gt = 1'b0;
              decided = 1'b0;
              for (int w = 0; w < N_KEY; w++)
                if (!decided && key_mem[j-1][w] != key_mem[j][w]) begin
                  gt = key_mem[j-1][w] > key_mem[j][w];
                  decided = 1'b1;
                end
              if (gt) begin
                for (int w = 0; w < N_KEY; w++) begin
                  t = key_mem[j-1][w];
                  key_mem[j-1][w] = key_mem[j][w];
                  key_mem[j][w] = t;
                end
                for (int w = 0; w < N_PAY; w++) begin
                  t = pay_mem[j-1][w];
                  pay_mem[j-1][w] = pay_mem[j][w];
                  pay_mem[j][w] = t;
                end
                j--;
              end else begin
                shifting = 1'b0;
              end
            end
          end
        end
      end
      default: begin
        r.status = ris_pkg::ST_RANGE;
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side. All tasks run from a rising edge and return at one.
  // --------------------------------------------------------------------------

  // One command transfer, with random idle cycles ahead of it. The payload
  // holds while stalled; the reply is predicted at the accepting edge.
  task automatic send_cmd(ris_pkg::in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    pending_replies.push_back(apply_command(it));
    sent_items++;
  endtask

  // Hold off the sender until every pending reply has been transferred.
  // Waits on a clock edge before the first check, so valid is never driven
  // twice in one step.
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  // All fields random; callers override the ones that matter.
  function automatic ris_pkg::in_item_t random_item();
    ris_pkg::in_item_t it;
    it.cmd          = 2'($urandom);
    it.record_index = 6'($urandom);
    it.word_index   = 3'($urandom);
    it.word_data    = {$urandom, $urandom};
    it.sort_count   = 7'($urandom);
    return it;
  endfunction

  // Key words from a small pool, so keys tie often, sometimes only late in
  // the key.
  function automatic logic [63:0] key_word_pick();
    case ($urandom_range(0, 5))
      0:       return 64'h0;
      1:       return 64'h4142_4300_0000_0000;  // "ABC", zero padded
      2:       return '1;
      3:       return 64'h4142_4344_4546_4748;  // "ABCDEFGH"
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic load_word(int rec, int w, logic [63:0] data);
    ris_pkg::in_item_t it;
    it              = random_item();
    it.cmd          = ris_pkg::CMD_LOAD;
    it.record_index = 6'(rec);
    it.word_index   = 3'(w);
    it.word_data    = data;
    send_cmd(it);
  endtask

  task automatic read_word_at(int rec, int w);
    ris_pkg::in_item_t it;
    it              = random_item();
    it.cmd          = ris_pkg::CMD_READ;
    it.record_index = 6'(rec);
    it.word_index   = 3'(w);
    send_cmd(it);
  endtask

  task automatic sort_records(int count);
    ris_pkg::in_item_t it;
    it            = random_item();
    it.cmd        = ris_pkg::CMD_SORT;
    it.sort_count = 7'(count);
    send_cmd(it);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Data extremes at the first and last record and word slots.
  task automatic test_word_extremes();
    load_word(0, 0, 64'h0);
    load_word(N_RECORDS - 1, N_WORDS - 1, '1);
    read_word_at(N_RECORDS - 1, N_WORDS - 1);
    read_word_at(0, 0);
  endtask

  // Bad word indexes, unused command, oversize counts: each flags range and
  // leaves the store as it was, which the final read confirms.
  task automatic test_bad_requests();
    ris_pkg::in_item_t it;
    load_word(N_RECORDS - 1, N_WORDS, 64'h0);
    read_word_at(0, 7);
    it = random_item();
    it.cmd = CMD_UNUSED;
    send_cmd(it);
    sort_records(N_RECORDS + 1);
    sort_records(127);
    read_word_at(N_RECORDS - 1, N_WORDS - 1);
  endtask

  // Sorts of zero and one record touch nothing and finish at once.
  task automatic test_short_sorts();
    sort_records(0);
    sort_records(1);
  endtask

  // Write every word of every record (after this no read or sort can reach
  // an unwritten entry), then sort the full store and sample it.
  task automatic test_fill_and_full_sort();
    for (int r = 0; r < N_RECORDS; r++)
      for (int w = 0; w < N_WORDS; w++)
        load_word(r, w, (w < N_KEY) ? key_word_pick() : {$urandom, $urandom});
    sort_records(N_RECORDS);
    repeat (8) read_word_at($urandom_range(0, N_RECORDS - 1), $urandom_range(0, N_WORDS - 1));
  endtask

  // Record 0 gets the largest key, records 1 and 2 the same smallest key:
  // the sort moves record 0 to the end and must keep 1 ahead of 2.
  task automatic test_equal_keys();
    for (int w = 0; w < N_KEY; w++) begin
      load_word(0, w, '1);
      load_word(1, w, 64'h0);
      load_word(2, w, 64'h0);
    end
    sort_records(3);
    for (int r = 0; r < 3; r++)
      read_word_at(r, N_KEY);
  endtask

  // Rounds of: rewrite words inside the range to sort, sort it, read back.
  // Fully random commands are mixed in as noise. Most counts are small to
  // keep the quadratic sort cheap; a few cover the whole store or are bad.
  task automatic test_random_rounds(int target);
    int first;
    int pick;
    int cnt;
    int rec_hi;
    int w;
    first = sent_items;
    while (sent_items - first < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 10)      cnt = $urandom_range(0, 1);
      else if (pick < 18) cnt = $urandom_range(N_RECORDS + 1, 127);
      else if (pick < 78) cnt = $urandom_range(2, 10);
      else if (pick < 92) cnt = $urandom_range(11, N_RECORDS - 1);
      else                cnt = N_RECORDS;
      rec_hi = (cnt >= 2 && cnt <= N_RECORDS) ? cnt - 1 : N_RECORDS - 1;

      repeat ($urandom_range(1, 16)) begin
        w = $urandom_range(0, N_WORDS - 1);
        load_word($urandom_range(0, rec_hi), w,
                  (w < N_KEY) ? key_word_pick() : {$urandom, $urandom});
        if ($urandom_range(0, 9) == 0) send_cmd(random_item());
      end

      // now and then sort with nothing else in flight
      if ($urandom_range(0, 3) == 0) wait_drain();
      sort_records(cnt);

      repeat ($urandom_range(2, 12)) begin
        read_word_at($urandom_range(0, rec_hi), $urandom_range(0, N_WORDS - 1));
        if ($urandom_range(0, 9) == 0) send_cmd(random_item());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Reply checker and receiver stalls
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : reply_check
    ris_pkg::out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_replies.size() == 0) begin
          $error("reply transfer with none pending: read_word %h status %0d",
                 out_data.read_word, out_data.status);
          error_count++;
        end else begin
          want = pending_replies.pop_front();
          if (out_data.read_word !== want.read_word) begin
            $error("read_word: expected %h, got %h", want.read_word, out_data.read_word);
            error_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            error_count++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset once, directed tests, full fill, then three random
  // phases with sender/receiver idling swapped and then switched off.
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_word_extremes();
    test_bad_requests();
    test_short_sorts();
    test_fill_and_full_sort();
    test_equal_keys();
    test_random_rounds(180);

    wait_drain();
    send_idle_pct = 61;
    recv_idle_pct = 23;
    test_random_rounds(180);

    wait_drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_rounds(180);

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

FILE: record_insertion_sorter_top.f
design/ris_pkg.sv
design/ris_store.sv
design/ris_sorter.sv
design/record_insertion_sorter_top.sv
design/ris_checker.sv
test/testbench.sv
